FILE: design/rfc_pkg.sv
// shared types and constants of the receive frame checker
package rfc_pkg;

    localparam logic [7:0] ACK_CODE_RESET = 8'hF3;
    localparam logic [7:0] SYNC_BYTE      = 8'h07;
    localparam logic [7:0] HDR_BYTE1      = 8'hF0;
    localparam logic [7:0] HDR_BYTE2      = 8'h00;
    localparam logic [7:0] TAIL_BYTE      = 8'h0F;
    localparam logic [7:0] SUM_SEED       = 8'hAD;
    localparam logic [7:0] FRAME_OVERHEAD = 8'd8;
    localparam logic [8:0] POS_MAX        = 9'd511;
    localparam logic [8:0] PAYLOAD_START  = 9'd5;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    localparam logic [2:0] ST_VALID    = 3'd0;
    localparam logic [2:0] ST_ACK      = 3'd1;
    localparam logic [2:0] ST_BAD_SIZE = 3'd2;
    localparam logic [2:0] ST_BAD_HDR  = 3'd3;
    localparam logic [2:0] ST_BAD_LEN  = 3'd4;
    localparam logic [2:0] ST_BAD_SUM  = 3'd5;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic [2:0] frame_status;
        logic [7:0] response_code;
        logic [7:0] payload_length;
    } result_t;

endpackage

FILE: design/rfc_if.sv
// channel interfaces for frame bytes and check results
interface rfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       last_byte;

    modport source (output valid, output rx_byte, output last_byte, input ready);
    modport sink   (input valid, input rx_byte, input last_byte, output ready);
endinterface

interface rfc_out_if;
    logic       valid;
    logic       ready;
    logic       result_kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [2:0] frame_status;
    logic [7:0] response_code;
    logic [7:0] payload_length;

    modport source (output valid, output result_kind, output payload_byte,
                    output payload_index, output frame_status, output response_code,
                    output payload_length, input ready);
    modport sink   (input valid, input result_kind, input payload_byte,
                    input payload_index, input frame_status, input response_code,
                    input payload_length, output ready);
endinterface

FILE: design/rfc_front.sv
// front end: per-byte frame tracking and classification into results
module rfc_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [7:0]       cfg_wdata,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       in_byte,
    input  logic             in_last,
    input  logic             q_full,
    output logic             push,
    output rfc_pkg::result_t push_data
);

    logic [7:0] ack_reg;
    logic [8:0] pos_reg, pos_next;
    logic       hdr_reg, hdr_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] cmd_reg, cmd_next;
    logic [7:0] r0_reg, r1_reg;

    logic       accept;
    logic       is_ack;
    logic       in_payload;
    logic [8:0] pay_off;
    logic [9:0] frame_len;
    logic [9:0] want_len;
    logic [7:0] sum_check;
    logic [2:0] status;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    assign is_ack = (pos_reg == 9'd1) && (r0_reg == rfc_pkg::SYNC_BYTE) &&
                    (in_byte == ack_reg);

    always_comb
    begin
        hdr_next = hdr_reg;
        unique case (pos_reg)
            9'd0:    hdr_next = (in_byte == rfc_pkg::SYNC_BYTE);
            9'd1:    hdr_next = hdr_reg && (in_byte == rfc_pkg::HDR_BYTE1);
            9'd2:    hdr_next = hdr_reg && (in_byte == rfc_pkg::HDR_BYTE2);
            default: hdr_next = hdr_reg;
        endcase
    end

    assign cmd_next   = (pos_reg == 9'd3) ? in_byte : cmd_reg;
    assign len_next   = (pos_reg == 9'd4) ? in_byte : len_reg;
    assign pay_off    = pos_reg - rfc_pkg::PAYLOAD_START;
    assign in_payload = (pos_reg >= rfc_pkg::PAYLOAD_START) && (pay_off < {1'b0, len_reg});
    assign sum_next   = ((pos_reg >= 9'd2 && pos_reg <= 9'd4) || in_payload) ?
                        sum_reg + in_byte : sum_reg;

    assign frame_len = {1'b0, pos_reg} + 10'd1;
    assign want_len  = {2'b00, len_next} + {2'b00, rfc_pkg::FRAME_OVERHEAD};
    assign sum_check = sum_next + rfc_pkg::SUM_SEED;

    always_comb
    begin
        if (pos_reg == 9'd0)
            status = rfc_pkg::ST_BAD_SIZE;
        else if (pos_reg == 9'd1)
            status = rfc_pkg::ST_BAD_HDR;
        else if (!(hdr_next && r0_reg == rfc_pkg::SYNC_BYTE && in_byte == rfc_pkg::TAIL_BYTE))
            status = rfc_pkg::ST_BAD_HDR;
        else if (frame_len != want_len)
            status = rfc_pkg::ST_BAD_LEN;
        else if (sum_check != r1_reg)
            status = rfc_pkg::ST_BAD_SUM;
        else
            status = rfc_pkg::ST_VALID;
    end

    always_comb
    begin
        push_data = '0;
        if (is_ack)
        begin
            push_data.result_kind  = rfc_pkg::KIND_STATUS;
            push_data.frame_status = rfc_pkg::ST_ACK;
        end
        else if (in_last)
        begin
            push_data.result_kind    = rfc_pkg::KIND_STATUS;
            push_data.frame_status   = status;
            push_data.response_code  = cmd_next;
            push_data.payload_length = len_next;
        end
        else
        begin
            push_data.result_kind   = rfc_pkg::KIND_PAYLOAD;
            push_data.payload_byte  = in_byte;
            push_data.payload_index = pay_off[7:0];
        end
    end

    assign push = accept && (in_last || (!is_ack && in_payload));

    assign pos_next = (pos_reg < rfc_pkg::POS_MAX) ? pos_reg + 9'd1 : pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ack_reg <= rfc_pkg::ACK_CODE_RESET;
        else if (cfg_we)
            ack_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            hdr_reg <= 1'b1;
            len_reg <= '0;
            sum_reg <= '0;
            cmd_reg <= '0;
            r0_reg  <= '0;
            r1_reg  <= '0;
        end
        else if (accept)
        begin
            // a stripped ack pair or the final byte starts a fresh frame
            if (is_ack || in_last)
            begin
                pos_reg <= '0;
                hdr_reg <= 1'b1;
                len_reg <= '0;
                sum_reg <= '0;
                cmd_reg <= '0;
                r0_reg  <= '0;
                r1_reg  <= '0;
            end
            else
            begin
                pos_reg <= pos_next;
                hdr_reg <= hdr_next;
                len_reg <= len_next;
                sum_reg <= sum_next;
                cmd_reg <= cmd_next;
                r0_reg  <= in_byte;
                r1_reg  <= r0_reg;
            end
        end
    end

endmodule

FILE: design/rfc_queue.sv
// short result queue between front and back ends
module rfc_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  rfc_pkg::result_t push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output rfc_pkg::result_t pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    rfc_pkg::result_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_pop;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk)
    begin
        if (push && !full)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push && !full)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if ((push && !full) && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (!(push && !full) && do_pop)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");

    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && !do_pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("queue count did not follow push");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");
`endif

endmodule

FILE: design/rfc_back.sv
// back end: output register that hands results to the result channel
module rfc_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_not_empty,
    input  rfc_pkg::result_t q_data,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output rfc_pkg::result_t out_data
);

    logic             vld_reg;
    rfc_pkg::result_t data_reg;

    // load whenever the register is free or being drained this cycle
    assign q_pop     = q_not_empty && (!vld_reg || out_ready);
    assign out_valid = vld_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (!vld_reg || out_ready)
            vld_reg <= q_not_empty;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            data_reg <= q_data;
    end

endmodule

FILE: design/rx_frame_checker.sv
// receive frame checker top level
// each result passes through the result queue and then the back-end output register
// throughput: one byte per cycle; the front end stalls only when the result queue is full
// a full queue follows from the result channel holding ready low
// reset (rst_n, async active low) clears frame tracking, queue and output valid
// ack_code returns to 0xF3 at reset
module rx_frame_checker
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    rfc_in_if.sink     rx,
    rfc_out_if.source  res
);

    logic             push;
    rfc_pkg::result_t push_data;
    logic             q_full;
    logic             q_pop;
    logic             q_not_empty;
    rfc_pkg::result_t q_data;
    rfc_pkg::result_t out_data;

    rfc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (rx.valid),
        .in_ready  (rx.ready),
        .in_byte   (rx.rx_byte),
        .in_last   (rx.last_byte),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    rfc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_data)
    );

    rfc_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .out_valid   (res.valid),
        .out_ready   (res.ready),
        .out_data    (out_data)
    );

    assign res.result_kind    = out_data.result_kind;
    assign res.payload_byte   = out_data.payload_byte;
    assign res.payload_index  = out_data.payload_index;
    assign res.frame_status   = out_data.frame_status;
    assign res.response_code  = out_data.response_code;
    assign res.payload_length = out_data.payload_length;

endmodule
